FILE: rtl/rpt_pkg.sv
// Shared types and constants for the rigid point transform block.
// Used by rpt_matrix, rpt_datapath and rigid_point_transform_core; no dependencies.
package rpt_pkg;

    localparam int unsigned CW = 32;     // coordinate and translation width, Q16.16
    localparam int unsigned QW = 16;     // quaternion part width, Q2.14
    localparam int unsigned PQW = 2 * QW; // product of two quaternion parts, Q.28
    localparam int unsigned EW = 36;     // matrix entry working width before rounding
    localparam int unsigned MW = 30;     // matrix entry width, Q.24
    localparam int unsigned PW = MW + CW; // coefficient times coordinate
    localparam int unsigned AW = 64;     // row accumulator width, Q.40
    localparam int unsigned FRAC_SHIFT = 24;
    localparam int unsigned NCOEF = 9;
    localparam int unsigned NAXIS = 3;
    localparam int unsigned IDXW = 3;
    localparam logic [1:0] SETTLE_CYCLES = 2'd2;

    localparam logic signed [EW-1:0] ONE_Q28 = EW'(64'sd268435456);
    localparam logic signed [EW-1:0] HALF_Q4 = EW'(64'sd8);
    localparam logic [FRAC_SHIFT-1:0] HALF_Q24 = 24'h800000;

    typedef logic signed [CW-1:0]  t_coord;
    typedef logic signed [QW-1:0]  t_quat;
    typedef logic signed [PQW-1:0] t_qprod;
    typedef logic signed [EW-1:0]  t_entry;
    typedef logic signed [MW-1:0]  t_coef;
    typedef logic signed [PW-1:0]  t_prod;
    typedef logic signed [AW-1:0]  t_acc;

    typedef enum logic [IDXW-1:0] {
        CFG_ROT_W   = 3'd0,
        CFG_ROT_X   = 3'd1,
        CFG_ROT_Y   = 3'd2,
        CFG_ROT_Z   = 3'd3,
        CFG_SHIFT_X = 3'd4,
        CFG_SHIFT_Y = 3'd5,
        CFG_SHIFT_Z = 3'd6
    } t_cfg_reg;

    // Row-major rotation matrix in Q.24 and the translation in Q16.16.
    typedef struct packed {
        logic [NCOEF-1:0][MW-1:0] m;
        logic [NAXIS-1:0][CW-1:0] shift;
    } t_xform;

endpackage

FILE: rtl/rpt_matrix.sv
// Configuration registers and the pipelined quaternion-to-matrix expansion.
// Depends on rpt_pkg.
module rpt_matrix (
    input  logic                    i_clk,
    input  logic                    i_rst_n,
    input  logic                    i_cfg_valid,
    input  logic [rpt_pkg::IDXW-1:0] i_cfg_index,
    input  logic [rpt_pkg::CW-1:0]  i_cfg_data,
    output rpt_pkg::t_xform         o_xf,
    output logic                    o_settling
);
    import rpt_pkg::*;

    t_quat  r_rot_w, r_rot_x, r_rot_y, r_rot_z;
    t_coord r_shift [NAXIS];
    t_qprod r_xx, r_yy, r_zz, r_xy, r_xz, r_yz, r_wx, r_wy, r_wz;
    t_coef  r_m [NCOEF];
    logic [1:0] r_settle;
    t_coef  n_m [NCOEF];

    function automatic t_coef to_q24(input t_entry r);
        t_entry t;
        t = r + HALF_Q4;
        return t[MW+3:4];
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rot_w  <= t_quat'(16'sd16384);
            r_rot_x  <= '0;
            r_rot_y  <= '0;
            r_rot_z  <= '0;
            r_shift[0] <= '0;
            r_shift[1] <= '0;
            r_shift[2] <= '0;
            r_settle <= SETTLE_CYCLES;
        end else begin
            if (i_cfg_valid) begin
                r_settle <= SETTLE_CYCLES;
                case (t_cfg_reg'(i_cfg_index))
                    CFG_ROT_W:   r_rot_w <= i_cfg_data[QW-1:0];
                    CFG_ROT_X:   r_rot_x <= i_cfg_data[QW-1:0];
                    CFG_ROT_Y:   r_rot_y <= i_cfg_data[QW-1:0];
                    CFG_ROT_Z:   r_rot_z <= i_cfg_data[QW-1:0];
                    CFG_SHIFT_X: r_shift[0] <= i_cfg_data;
                    CFG_SHIFT_Y: r_shift[1] <= i_cfg_data;
                    CFG_SHIFT_Z: r_shift[2] <= i_cfg_data;
                    default: begin
                    end
                endcase
            end else if (r_settle != 2'd0) begin
                r_settle <= r_settle - 2'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_xx <= PQW'(r_rot_x) * PQW'(r_rot_x);
        r_yy <= PQW'(r_rot_y) * PQW'(r_rot_y);
        r_zz <= PQW'(r_rot_z) * PQW'(r_rot_z);
        r_xy <= PQW'(r_rot_x) * PQW'(r_rot_y);
        r_xz <= PQW'(r_rot_x) * PQW'(r_rot_z);
        r_yz <= PQW'(r_rot_y) * PQW'(r_rot_z);
        r_wx <= PQW'(r_rot_w) * PQW'(r_rot_x);
        r_wy <= PQW'(r_rot_w) * PQW'(r_rot_y);
        r_wz <= PQW'(r_rot_w) * PQW'(r_rot_z);
        for (int i = 0; i < NCOEF; i++) begin
            r_m[i] <= n_m[i];
        end
    end

    always_comb begin
        n_m[0] = to_q24(ONE_Q28 - ((EW'(r_yy) + EW'(r_zz)) <<< 1));
        n_m[1] = to_q24((EW'(r_xy) - EW'(r_wz)) <<< 1);
        n_m[2] = to_q24((EW'(r_xz) + EW'(r_wy)) <<< 1);
        n_m[3] = to_q24((EW'(r_xy) + EW'(r_wz)) <<< 1);
        n_m[4] = to_q24(ONE_Q28 - ((EW'(r_xx) + EW'(r_zz)) <<< 1));
        n_m[5] = to_q24((EW'(r_yz) - EW'(r_wx)) <<< 1);
        n_m[6] = to_q24((EW'(r_xz) - EW'(r_wy)) <<< 1);
        n_m[7] = to_q24((EW'(r_yz) + EW'(r_wx)) <<< 1);
        n_m[8] = to_q24(ONE_Q28 - ((EW'(r_xx) + EW'(r_yy)) <<< 1));
    end

    always_comb begin
        for (int i = 0; i < NCOEF; i++) begin
            o_xf.m[i] = r_m[i];
        end
        for (int i = 0; i < NAXIS; i++) begin
            o_xf.shift[i] = r_shift[i];
        end
    end

    assign o_settling = (r_settle != 2'd0);

endmodule

FILE: rtl/rpt_datapath.sv
// Five-stage point pipeline: capture, multiply, partial sums, row sum, round and clip.
// Depends on rpt_pkg.
module rpt_datapath (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_valid,
    input  rpt_pkg::t_coord        i_x,
    input  rpt_pkg::t_coord        i_y,
    input  rpt_pkg::t_coord        i_z,
    input  logic                   i_last,
    input  rpt_pkg::t_xform        i_xf,
    output logic                   o_valid,
    output rpt_pkg::t_coord        o_x,
    output rpt_pkg::t_coord        o_y,
    output rpt_pkg::t_coord        o_z,
    output logic                   o_last,
    output logic                   o_sat
);
    import rpt_pkg::*;

    logic   r_s1_vld, r_s2_vld, r_s3_vld, r_s4_vld, r_out_vld;
    logic   r_s1_last, r_s2_last, r_s3_last, r_s4_last, r_out_last;
    t_coord r_s1_p [NAXIS];
    t_prod  r_s2_prod [NCOEF];
    t_acc   r_s3_pa [NAXIS];
    t_acc   r_s3_pb [NAXIS];
    t_acc   r_s4_acc [NAXIS];
    t_coord r_out_c [NAXIS];
    logic   r_out_sat;
    t_acc   n_tval [NAXIS];
    t_coord n_c [NAXIS];
    logic [NAXIS-1:0] n_clip;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld  <= 1'b0;
            r_s2_vld  <= 1'b0;
            r_s3_vld  <= 1'b0;
            r_s4_vld  <= 1'b0;
            r_out_vld <= 1'b0;
        end else begin
            r_s1_vld  <= i_valid;
            r_s2_vld  <= r_s1_vld;
            r_s3_vld  <= r_s2_vld;
            r_s4_vld  <= r_s3_vld;
            r_out_vld <= r_s4_vld;
        end
    end

    always_comb begin
        for (int i = 0; i < NAXIS; i++) begin
            n_tval[i] = {{(AW-CW-FRAC_SHIFT){i_xf.shift[i][CW-1]}}, i_xf.shift[i], HALF_Q24};
        end
    end

    always_comb begin
        for (int i = 0; i < NAXIS; i++) begin
            n_clip[i] = !((&r_s4_acc[i][AW-1:CW+FRAC_SHIFT-1])
                          || !(|r_s4_acc[i][AW-1:CW+FRAC_SHIFT-1]));
            if (!n_clip[i]) begin
                n_c[i] = r_s4_acc[i][CW+FRAC_SHIFT-1:FRAC_SHIFT];
            end else if (r_s4_acc[i][AW-1]) begin
                n_c[i] = {1'b1, {(CW-1){1'b0}}};
            end else begin
                n_c[i] = {1'b0, {(CW-1){1'b1}}};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        r_s1_p[0] <= i_x;
        r_s1_p[1] <= i_y;
        r_s1_p[2] <= i_z;
        r_s1_last <= i_last;

        for (int i = 0; i < NCOEF; i++) begin
            r_s2_prod[i] <= PW'($signed(i_xf.m[i])) * PW'(r_s1_p[i % NAXIS]);
        end
        r_s2_last <= r_s1_last;

        for (int i = 0; i < NAXIS; i++) begin
            r_s3_pa[i] <= AW'(r_s2_prod[i*NAXIS]) + AW'(r_s2_prod[i*NAXIS+1]);
            r_s3_pb[i] <= AW'(r_s2_prod[i*NAXIS+2]) + n_tval[i];
        end
        r_s3_last <= r_s2_last;

        for (int i = 0; i < NAXIS; i++) begin
            r_s4_acc[i] <= r_s3_pa[i] + r_s3_pb[i];
        end
        r_s4_last <= r_s3_last;

        for (int i = 0; i < NAXIS; i++) begin
            r_out_c[i] <= n_c[i];
        end
        r_out_last <= r_s4_last;
        r_out_sat  <= |n_clip;
    end

    assign o_valid = r_out_vld;
    assign o_x     = r_out_c[0];
    assign o_y     = r_out_c[1];
    assign o_z     = r_out_c[2];
    assign o_last  = r_out_last;
    assign o_sat   = r_out_sat;

endmodule

FILE: rtl/rigid_point_transform_core.sv
// Top level of the rigid point transform: rotates each point by a quaternion matrix and
// translates it. Depends on rpt_pkg, rpt_matrix and rpt_datapath.
//
// Use: load rot_w/x/y/z (Q2.14) and shift_x/y/z (Q16.16) over the configuration channel,
// indexes 0 to 6; other indexes are ignored. The channel is always ready.
// After any configuration beat, and after reset, o_busy stays high while the rotation
// matrix is rebuilt. Configure only while no point is in flight.
// A point is taken at each rising edge with i_start high and o_busy low, so one point
// per cycle is sustained. Its result appears on o_out_* for exactly one cycle with o_done
// high; the receiver cannot stall, and the pipeline never waits.
// Each point passes through the input register, the multiply stage, two adder stages
// and the round and clip stage.
// o_saturated flags a result where any coordinate was clipped to the 32-bit range;
// o_out_last copies i_in_last.
// Reset is synchronous and active low: it empties the pipeline, restores the identity
// rotation and zero translation, and drops o_done.
module rigid_point_transform_core (
    input  logic                     i_clk,
    input  logic                     i_rst_n,
    input  logic                     i_start,
    output logic                     o_busy,
    input  logic signed [31:0]       i_in_x,
    input  logic signed [31:0]       i_in_y,
    input  logic signed [31:0]       i_in_z,
    input  logic                     i_in_last,
    output logic                     o_done,
    output logic signed [31:0]       o_out_x,
    output logic signed [31:0]       o_out_y,
    output logic signed [31:0]       o_out_z,
    output logic                     o_out_last,
    output logic                     o_saturated,
    input  logic                     i_cfg_valid,
    output logic                     o_cfg_ready,
    input  logic [rpt_pkg::IDXW-1:0] i_cfg_index,
    input  logic [rpt_pkg::CW-1:0]   i_cfg_data
);
    import rpt_pkg::*;

    t_xform xf;
    logic   settling;
    logic   accept;
    logic   cfg_write;

    assign o_cfg_ready = 1'b1;
    assign cfg_write   = i_cfg_valid && o_cfg_ready;
    assign o_busy      = settling;
    assign accept      = i_start && !settling;

    rpt_matrix u_matrix (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (cfg_write),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data),
        .o_xf        (xf),
        .o_settling  (settling)
    );

    rpt_datapath u_datapath (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (accept),
        .i_x     (i_in_x),
        .i_y     (i_in_y),
        .i_z     (i_in_z),
        .i_last  (i_in_last),
        .i_xf    (xf),
        .o_valid (o_done),
        .o_x     (o_out_x),
        .o_y     (o_out_y),
        .o_z     (o_out_z),
        .o_last  (o_out_last),
        .o_sat   (o_saturated)
    );

`ifndef NO_ASSERTIONS
    a_cfg_blocks_start: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cfg_write |=> o_busy)
        else $error("busy not raised after a configuration beat");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> ##4 o_done)
        else $error("accepted point gave no result five cycles later");

    a_result_has_source: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_done |-> $past(accept, 5))
        else $error("result strobe without a matching accepted point");
`endif

endmodule
